// ----- design/ggh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggh_pkg: shared types and constants for the gyro/GPS heading fusion block
// Word formats, register indexes, controller states, control structs and the
// angle wrap helper.
// ----------------------------------------------------------------------------
package ggh_pkg;

  typedef struct packed {
    logic signed [15:0] yaw_rate;
    logic [15:0]        step_time;
    logic               fix_updated;
    logic               course_valid;
    logic [15:0]        course_angle;
    logic [15:0]        ground_speed;
  } in_word_t;

  typedef struct packed {
    logic signed [32:0] heading;
    logic               initialized;
  } out_word_t;

  localparam int CFG_DATA_W = 27;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND      = 2'd3;

  localparam logic signed [15:0] GYRO_BIAS_RST = 16'sd0;
  localparam logic [15:0]        MIN_SPEED_RST = 16'd50;
  localparam logic [26:0]        INTERVAL_RST  = 27'd10000000;
  localparam logic [8:0]         BLEND_RST     = 9'd128;

  // Heading LSB is 1/16e6 degree; a full turn is 360 * 16e6.
  localparam logic signed [35:0] HALF_TURN = 36'sd2880000000;
  localparam logic signed [35:0] FULL_TURN = 36'sd5760000000;
  localparam logic signed [32:0] HEAD_MAX  = 33'sd2880000000;
  localparam logic signed [32:0] HEAD_MIN  = -33'sd2880000000;

  // Course in centidegrees, wrapped before scaling to heading LSBs.
  localparam logic signed [17:0] COURSE_HALF_CD = 18'sd18000;
  localparam logic signed [17:0] COURSE_FULL_CD = 18'sd36000;
  localparam logic signed [18:0] COURSE_SCALE   = 19'sd160000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GYRO,
    ST_HEAD,
    ST_CORR,
    ST_BLEND,
    ST_APPLY,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic gyro_mul;
    logic head_upd;
    logic corr;
    logic blend_mul;
    logic blend_apply;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic do_blend;
    logic out_free;
  } ctrl_status_t;

  // One wrap step; every caller stays within one full turn of the range.
  function automatic logic signed [35:0] wrap_angle(input logic signed [35:0] a);
    logic signed [35:0] r;
    r = a;
    if (a > HALF_TURN) begin
      r = a - FULL_TURN;
    end else if (a < -HALF_TURN) begin
      r = a + FULL_TURN;
    end
    return r;
  endfunction

endpackage

// ----- design/ggh_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggh_ctrl: sequencer for the heading fusion datapath
// Steps one tick through gyro integration, correction and result load.
// ----------------------------------------------------------------------------
module ggh_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  ggh_pkg::ctrl_status_t status,
  output ggh_pkg::ctrl_cmd_t    cmd
);
  import ggh_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_GYRO;
        end
      end
      ST_GYRO: begin
        cmd.gyro_mul = 1'b1;
        state_next   = ST_HEAD;
      end
      ST_HEAD: begin
        cmd.head_upd = 1'b1;
        state_next   = ST_CORR;
      end
      ST_CORR: begin
        cmd.corr   = 1'b1;
        state_next = status.do_blend ? ST_BLEND : ST_OUT;
      end
      ST_BLEND: begin
        cmd.blend_mul = 1'b1;
        state_next    = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.blend_apply = 1'b1;
        state_next      = ST_OUT;
      end
      ST_OUT: begin
        // Wait here while the previous word still sits in the output register.
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/ggh_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggh_datapath: heading state, config registers and shared multiplier
// One registered signed multiplier serves the gyro, course and blend products.
// ----------------------------------------------------------------------------
module ggh_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ggh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ggh_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  ggh_pkg::in_word_t                sample,
  output ggh_pkg::out_word_t               result,
  output logic                             result_valid,
  input  logic                             result_ready,
  input  ggh_pkg::ctrl_cmd_t               cmd,
  output ggh_pkg::ctrl_status_t            status
);
  import ggh_pkg::*;

  logic signed [15:0] gyro_bias;
  logic [15:0]        min_speed;
  logic [26:0]        interval;
  logic [8:0]         blend_weight;

  logic signed [16:0] rate_diff;
  logic [15:0]        step_dt;
  logic signed [16:0] course_cd;
  logic               course_hi;
  logic               usable;

  logic signed [32:0] heading;
  logic [26:0]        since;
  logic               init_flag;
  logic               do_snap;
  logic               do_blend;
  logic signed [33:0] err;
  logic signed [53:0] prod;

  logic signed [17:0] course_raw;
  logic signed [17:0] course_w1;
  logic signed [17:0] course_w2;
  logic signed [34:0] mul_a;
  logic signed [18:0] mul_b;
  logic [27:0]        since_sum;
  logic [26:0]        since_sat;
  logic signed [35:0] head_gyro;
  logic signed [35:0] err_full;
  logic signed [35:0] head_blend;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_bias    <= GYRO_BIAS_RST;
      min_speed    <= MIN_SPEED_RST;
      interval     <= INTERVAL_RST;
      blend_weight <= BLEND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GYRO_BIAS: gyro_bias    <= $signed(cfg_data[15:0]);
        REG_MIN_SPEED: min_speed    <= cfg_data[15:0];
        REG_INTERVAL:  interval     <= cfg_data[26:0];
        REG_BLEND:     blend_weight <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Course over ground can exceed a turn; wrap it in centidegrees first.
  always_comb begin
    course_raw = $signed({2'b00, sample.course_angle});
    course_w1  = (course_raw > COURSE_HALF_CD) ? course_raw - COURSE_FULL_CD : course_raw;
    course_w2  = (course_w1 > COURSE_HALF_CD) ? course_w1 - COURSE_FULL_CD : course_w1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate_diff <= 17'(sample.yaw_rate) - 17'(gyro_bias);
      step_dt   <= sample.step_time;
      course_cd <= course_w2[16:0];
      course_hi <= (course_raw > COURSE_HALF_CD);
      usable    <= sample.fix_updated & sample.course_valid &
                   (sample.ground_speed >= min_speed);
    end
  end

  always_comb begin
    if (cmd.gyro_mul) begin
      mul_a = 35'(rate_diff);
      mul_b = $signed({3'b000, step_dt});
    end else if (cmd.blend_mul) begin
      mul_a = 35'(err);
      mul_b = $signed({10'd0, blend_weight});
    end else begin
      mul_a = 35'(course_cd);
      mul_b = COURSE_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    since_sum  = {1'b0, since} + {12'd0, step_dt};
    since_sat  = (since_sum > {1'b0, interval}) ? interval : since_sum[26:0];
    head_gyro  = wrap_angle(36'(heading) + $signed(prod[35:0]));
    err_full   = wrap_angle($signed(prod[35:0]) - 36'(heading));
    // Bits 8 and above of the product are the floor of weight * error / 256.
    head_blend = wrap_angle(36'(heading) + $signed(prod[43:8]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heading   <= '0;
      since     <= '0;
      init_flag <= 1'b0;
      do_snap   <= 1'b0;
      do_blend  <= 1'b0;
    end else begin
      if (cmd.head_upd) begin
        heading  <= head_gyro[32:0];
        since    <= since_sat;
        do_snap  <= usable & ~init_flag;
        do_blend <= usable & init_flag & (since_sat >= interval);
      end
      if (cmd.corr && do_snap) begin
        heading   <= prod[32:0];
        init_flag <= 1'b1;
        since     <= '0;
      end
      if (cmd.blend_apply) begin
        heading <= head_blend[32:0];
        since   <= '0;
      end
    end
  end

  // An unwrapped course above a half turn reaches an exact half-turn error from
  // above, so that tie resolves to plus a half turn instead of minus.
  always_ff @(posedge clk) begin
    if (cmd.corr) begin
      if (course_hi && (err_full == -HALF_TURN)) begin
        err <= HALF_TURN[33:0];
      end else begin
        err <= err_full[33:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.heading     <= heading;
      result.initialized <= init_flag;
    end
  end

  assign status.do_blend = do_blend;
  assign status.out_free = ~result_valid | result_ready;

endmodule

// ----- design/gyro_gps_heading_fusion.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_gps_heading_fusion: complementary heading filter, gyro plus GPS course
//
//   channel   signals                                 direction
//   sample    sample_valid, sample_ready, sample      in  (one update tick)
//   result    result_valid, result_ready, result      out (heading, initialized)
//   config    cfg_we, cfg_index, cfg_data             in  (write only)
//
// A result word passes the sequencer states GYRO, HEAD, CORR and OUT after its
// sample is accepted, with BLEND and APPLY before OUT when a blend correction
// runs, since the single shared multiplier is used in sequence for the gyro
// product, the course scaling and the blend product. The next sample is taken
// in the cycle after the output load, so samples are worked on one at a time.
// Reset is synchronous; all filter state and config registers return to defaults.
// The output register holds one word; a stalled result_ready holds the
// sequencer before the load, and no new sample is taken until then.
// ----------------------------------------------------------------------------
module gyro_gps_heading_fusion (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ggh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ggh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  ggh_pkg::in_word_t              sample,
  output logic                           result_valid,
  input  logic                           result_ready,
  output ggh_pkg::out_word_t             result
);
  import ggh_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  ggh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  ggh_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status)
  );

  // Only one datapath step is commanded in any cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command active");

  // A word is worked on alone: no second sample right after acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while previous word in progress");

  // The blend step always follows its product.
  a_blend_order: assert property (@(posedge clk) disable iff (rst)
    cmd.blend_apply |-> $past(cmd.blend_mul))
    else $error("blend applied without a fresh product");

  // Heading leaves the block wrapped into the half-turn range.
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.heading <= HEAD_MAX) && (result.heading >= HEAD_MIN))
    else $error("heading out of range");

endmodule
